### sv/bvx_pkg.sv
package bvx_pkg;

  localparam int WORD_BITS     = 32;
  localparam int DEF_VEC_WORDS = 8;
  localparam int CFG_W         = 9;
  localparam int ACT_W         = 4;
  localparam int OFF_W         = 17;
  localparam int IN_TDATA_W    = 72;

  localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

  // action codes
  localparam logic [ACT_W-1:0] ACT_FILL   = 4'd0;
  localparam logic [ACT_W-1:0] ACT_WRA    = 4'd1;
  localparam logic [ACT_W-1:0] ACT_WRB    = 4'd2;
  localparam logic [ACT_W-1:0] ACT_NOT    = 4'd3;
  localparam logic [ACT_W-1:0] ACT_AND    = 4'd4;
  localparam logic [ACT_W-1:0] ACT_OR     = 4'd5;
  localparam logic [ACT_W-1:0] ACT_XOR    = 4'd6;
  localparam logic [ACT_W-1:0] ACT_GETBIT = 4'd7;
  localparam logic [ACT_W-1:0] ACT_RDWORD = 4'd8;
  localparam logic [ACT_W-1:0] ACT_EXTZ   = 4'd9;
  localparam logic [ACT_W-1:0] ACT_EXTW   = 4'd10;
  localparam logic [ACT_W-1:0] ACT_JOIN   = 4'd11;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic ser_step;
    logic emit;
  } bvx_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             err;
    logic             short_len;
    logic             div_done;
    logic             ser_done;
    logic             last;
  } bvx_stat_t;

endpackage

### sv/bit_vector_extract_logic_engine_unit.sv
// Bit-vector logic engine: holds vectors A and B of a configured length.
// Input channel in_*: one item per action; in_tuser carries the action code,
// in_tdata carries the operands. Result channel out_*: result words, with
// out_tlast on the final word of an action and out_tuser set on an error.
// cfg_wr_en/cfg_wr_data write the vector length; stored bits above the new
// length are cleared in the same cycle.
// Actions that only modify A or B give no result word. Bit and word reads
// give one word, which passes the dispatch and emit states into the result
// register. Extract-zero and join give one word per cycle after the dispatch
// state while the receiver is ready, up to 8 words. Extract-wrap first reduces
// the offset modulo the length in a remainder loop; then, while the receiver
// is ready, one word per cycle for lengths of 32 bits and up, or for shorter
// vectors each bit is gathered serially.
// The next item is taken once the last word sits in the output register.
// A stalled receiver holds the output register and the sequencer waits.
// Reset clears both vectors, sets the length to 256 bits, drops out_tvalid.
module bit_vector_extract_logic_engine_unit #(
  parameter int VEC_WORDS = bvx_pkg::DEF_VEC_WORDS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [bvx_pkg::CFG_W-1:0]       cfg_wr_data,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // fill_bit, word_index, word_data, offset, length, split
  input  logic [bvx_pkg::IN_TDATA_W-1:0]  in_tdata,
  // action
  input  logic [bvx_pkg::ACT_W-1:0]       in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // data
  output logic [31:0]                     out_tdata,
  output logic                            out_tlast,
  // error
  output logic                            out_tuser
);
  import bvx_pkg::*;

  bvx_cmd_t  cmd;
  bvx_stat_t stat;

  bvx_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  bvx_datapath #(.VEC_WORDS(VEC_WORDS)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .action      (in_tuser),
    .fill_bit    (in_tdata[0]),
    .word_index  (in_tdata[3:1]),
    .word_data   (in_tdata[35:4]),
    .offset      (in_tdata[52:36]),
    .length      (in_tdata[61:53]),
    .split       (in_tdata[70:62]),
    .cmd         (cmd),
    .stat        (stat),
    .out_data    (out_tdata),
    .out_last    (out_tlast),
    .out_err     (out_tuser)
  );

`ifndef SYNTH
  // an error result is a single zero word
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && out_tdata == 32'h0)
    else $error("error result not a single zero word");

  // an accepted item blocks the input until it has been dispatched
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after accept");

  // a result is loaded only after the previous one was taken or the slot was empty
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("pending result overwritten");
`endif

endmodule

### sv/bvx_datapath.sv
module bvx_datapath #(
  parameter int VEC_WORDS = bvx_pkg::DEF_VEC_WORDS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [bvx_pkg::CFG_W-1:0]     cfg_wr_data,
  input  logic [bvx_pkg::ACT_W-1:0]     action,
  input  logic                          fill_bit,
  input  logic [2:0]                    word_index,
  input  logic [31:0]                   word_data,
  input  logic [bvx_pkg::OFF_W-1:0]     offset,
  input  logic [8:0]                    length,
  input  logic [8:0]                    split,
  input  bvx_pkg::bvx_cmd_t             cmd,
  output bvx_pkg::bvx_stat_t            stat,
  output logic [31:0]                   out_data,
  output logic                          out_last,
  output logic                          out_err
);
  import bvx_pkg::*;

  localparam int NB = VEC_WORDS * WORD_BITS;
  localparam int LW = $clog2(NB + 1);
  localparam int KW = $clog2(VEC_WORDS + 1);
  localparam int IW = $clog2(NB);
  localparam int XW = ((LW > CFG_W) ? LW : CFG_W) + 2;

  function automatic logic [LW-1:0] eff_len(input logic [CFG_W-1:0] v);
    logic [XW-1:0] vx;
    vx = XW'(v);
    if (vx == '0) vx = XW'(1);
    if (vx > XW'(NB)) vx = XW'(NB);
    return vx[LW-1:0];
  endfunction

  function automatic logic [NB-1:0] len_mask(input logic [LW-1:0] l);
    logic [XW-1:0] sh;
    sh = XW'(NB) - XW'(l);
    return {NB{1'b1}} >> sh;
  endfunction

  function automatic logic [31:0] low_mask(input logic [XW-1:0] n);
    logic [31:0] m;
    if (n >= XW'(WORD_BITS)) m = '1;
    else m = (32'h1 << n[4:0]) - 32'h1;
    return m;
  endfunction

  // stored vectors and length
  logic [NB-1:0]      a_r, a_nxt, b_r, b_nxt;
  logic [CFG_W-1:0]   vbits_r, vbits_nxt;
  // latched item
  logic [ACT_W-1:0]   act_r;
  logic [OFF_W-1:0]   off_r;
  logic [2:0]         widx_r;
  logic [8:0]         split_r;
  logic [LW-1:0]      llen_r;
  logic [KW-1:0]      nw_r, cnt_r;
  logic               err_r, neg_r;
  // wrap pointer, divider and serial state
  logic [LW-1:0]      p_r;
  logic [OFF_W-1:0]   dvd_r;
  logic [4:0]         c5_r;
  logic [31:0]        acc_r;
  // result register
  logic [31:0]        data_r;
  logic               last_r, oerr_r;

  logic [LW-1:0]      len_c, cfg_len;
  logic [NB-1:0]      lmask, cmask, wsel, wdat, shr_p, shl_p, shr_z, a_k, b_k;
  logic               wr_ok, is_ext, cur_last;
  logic [XW-1:0]      kb, rem, jd, len_x, px, remx;
  logic [LW:0]        dv;
  logic [LW-1:0]      dv_sub, dv_fix;
  logic signed [18:0] pos, npos;
  logic [31:0]        zword, wword, jmask, word_c, emask;
  logic [KW-1:0]      nw_c;
  logic [XW-1:0]      llen_x;

  function automatic logic c_short();
    return (len_c < LW'(WORD_BITS));
  endfunction

  function automatic logic [31:0] a_k_w();
    logic [NB-1:0] t;
    t = a_r >> {widx_r, 5'b0};
    return t[31:0];
  endfunction

  assign len_c   = eff_len(vbits_r);
  assign cfg_len = eff_len(cfg_wr_data);
  assign lmask   = len_mask(len_c);
  assign cmask   = len_mask(cfg_len);
  assign len_x   = XW'(len_c);

  // vector updates from configuration and modifying actions
  assign wr_ok = (8'(word_index) < 8'(VEC_WORDS));
  assign wsel  = NB'(32'hFFFF_FFFF) << {word_index, 5'b0};
  assign wdat  = NB'(word_data) << {word_index, 5'b0};

  always_comb begin
    a_nxt     = a_r;
    b_nxt     = b_r;
    vbits_nxt = vbits_r;
    if (cfg_wr_en) begin
      vbits_nxt = cfg_wr_data;
      a_nxt     = a_r & cmask;
      b_nxt     = b_r & cmask;
    end else if (cmd.load) begin
      case (action)
        ACT_FILL: a_nxt = fill_bit ? lmask : '0;
        ACT_WRA:  if (wr_ok) a_nxt = (a_r & ~wsel) | (wdat & wsel & lmask);
        ACT_WRB:  if (wr_ok) b_nxt = (b_r & ~wsel) | (wdat & wsel & lmask);
        ACT_NOT:  a_nxt = ~a_r & lmask;
        ACT_AND:  a_nxt = (a_r & b_r) & lmask;
        ACT_OR:   a_nxt = (a_r | b_r) & lmask;
        ACT_XOR:  a_nxt = (a_r ^ b_r) & lmask;
        default:  a_nxt = a_r;
      endcase
    end
  end

  // load-time decode
  assign is_ext = (action == ACT_EXTZ) || (action == ACT_EXTW);
  assign llen_x = (XW'(length) > XW'(NB)) ? XW'(NB) : XW'(length);

  always_comb begin
    if (is_ext) nw_c = KW'((llen_x + XW'(31)) >> 5);
    else if (action == ACT_JOIN) nw_c = KW'((len_x + XW'(31)) >> 5);
    else nw_c = KW'(1);
  end

  // remainder step of |offset| mod length, one bit per cycle
  assign dv     = {p_r, dvd_r[OFF_W-1]};
  assign dv_sub = ((LW+1)'(dv) >= (LW+1)'(len_c)) ? LW'(dv - (LW+1)'(len_c)) : LW'(dv);
  assign dv_fix = (neg_r && dv_sub != '0) ? LW'(len_c - dv_sub) : dv_sub;

  // result word for the current position
  assign kb   = XW'({cnt_r, 5'b0});
  assign pos  = {{2{off_r[OFF_W-1]}}, off_r} + 19'({cnt_r, 5'b0});
  assign npos = -pos;
  assign shr_z = a_r >> pos[17:0];

  always_comb begin
    if (!pos[18]) zword = shr_z[31:0];
    else if (npos < 19'sd32) zword = a_r[31:0] << npos[4:0];
    else zword = '0;
  end

  assign shr_p = a_r >> p_r;
  assign shl_p = a_r << (len_c - p_r);
  assign wword = c_short() ? acc_r : (shr_p[31:0] | shl_p[31:0]);

  assign a_k   = a_r >> {cnt_r, 5'b0};
  assign b_k   = b_r >> {cnt_r, 5'b0};
  assign jd    = XW'(split_r) - kb;
  assign jmask = (XW'(split_r) <= kb) ? 32'h0 : low_mask(jd);
  assign rem   = XW'(llen_r) - kb;
  assign emask = cur_last ? low_mask(rem) : 32'hFFFF_FFFF;
  assign cur_last = (XW'(cnt_r) + XW'(1) == XW'(nw_r));

  always_comb begin
    word_c = '0;
    if (!err_r) begin
      case (act_r)
        ACT_GETBIT: word_c = {31'b0, (!off_r[OFF_W-1] && (off_r[15:0] < 16'(NB)))
                                      ? a_r[off_r[IW-1:0]] : 1'b0};
        ACT_RDWORD: word_c = (8'(widx_r) < 8'(VEC_WORDS)) ? a_k_w() : 32'h0;
        ACT_EXTZ:   word_c = zword & emask;
        ACT_EXTW:   word_c = wword & emask;
        ACT_JOIN:   word_c = (a_k[31:0] & jmask) | (b_k[31:0] & ~jmask);
        default:    word_c = '0;
      endcase
    end
  end

  // pointer advance by one word for the wide wrap case
  assign px   = XW'(p_r) + XW'(WORD_BITS);
  assign remx = (px >= len_x) ? (px - len_x) : px;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r     <= '0;
      b_r     <= '0;
      vbits_r <= CFG_RESET;
      act_r   <= ACT_FILL;
      err_r   <= 1'b0;
      cnt_r   <= '0;
      nw_r    <= '0;
      c5_r    <= '0;
    end else begin
      a_r     <= a_nxt;
      b_r     <= b_nxt;
      vbits_r <= vbits_nxt;
      if (cmd.load) begin
        act_r   <= action;
        off_r   <= offset;
        widx_r  <= word_index;
        split_r <= split;
        llen_r  <= LW'(llen_x);
        nw_r    <= nw_c;
        cnt_r   <= '0;
        c5_r    <= '0;
        p_r     <= '0;
        neg_r   <= offset[OFF_W-1];
        dvd_r   <= offset[OFF_W-1] ? (~offset + OFF_W'(1)) : offset;
        err_r   <= (is_ext && length == '0) ||
                   ((action == ACT_JOIN) && (XW'(split) > len_x));
      end
      // modulo reduction of the start offset
      if (cmd.div_step) begin
        dvd_r <= dvd_r << 1;
        c5_r  <= (c5_r == 5'd16) ? 5'd0 : c5_r + 5'd1;
        p_r   <= (c5_r == 5'd16) ? dv_fix : dv_sub;
      end
      // one wrapped bit per cycle for short vectors
      if (cmd.ser_step) begin
        acc_r[c5_r] <= a_r[p_r[IW-1:0]];
        c5_r        <= c5_r + 5'd1;
        p_r         <= (XW'(p_r) + XW'(1) == len_x) ? '0 : LW'(p_r + LW'(1));
      end
      if (cmd.emit) begin
        data_r <= word_c;
        last_r <= cur_last || err_r;
        oerr_r <= err_r;
        cnt_r  <= KW'(cnt_r + KW'(1));
        if (!c_short()) p_r <= LW'(remx);
      end
    end
  end

  assign stat.act       = act_r;
  assign stat.err       = err_r;
  assign stat.short_len = c_short();
  assign stat.div_done  = (c5_r == 5'd16);
  assign stat.ser_done  = (c5_r == 5'd31);
  assign stat.last      = cur_last || err_r;

  assign out_data = data_r;
  assign out_last = last_r;
  assign out_err  = oerr_r;

endmodule

### sv/bvx_ctrl.sv
module bvx_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  bvx_pkg::bvx_stat_t stat,
  output bvx_pkg::bvx_cmd_t  cmd
);
  import bvx_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_DISP, S_DIV, S_SER, S_EMIT} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  // commands
  always_comb begin
    cmd          = '0;
    cmd.load     = in_tvalid && in_tready;
    cmd.div_step = (state_r == S_DIV);
    cmd.ser_step = (state_r == S_SER);
    cmd.emit     = (state_r == S_EMIT) && (!out_valid_r || out_tready);
  end

  // sequencing
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (cmd.load) state_nxt = S_DISP;
      S_DISP: begin
        if (stat.err) state_nxt = S_EMIT;
        else begin
          case (stat.act) inside
            ACT_GETBIT, ACT_RDWORD, ACT_EXTZ, ACT_JOIN: state_nxt = S_EMIT;
            ACT_EXTW: state_nxt = S_DIV;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_DIV: if (stat.div_done) state_nxt = stat.short_len ? S_SER : S_EMIT;
      S_SER: if (stat.ser_done) state_nxt = S_EMIT;
      S_EMIT: begin
        if (cmd.emit) begin
          if (stat.last) state_nxt = S_IDLE;
          else if (stat.act == ACT_EXTW && stat.short_len) state_nxt = S_SER;
          else state_nxt = S_EMIT;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### tb/sv/bit_vector_extract_logic_engine_unit_test.sv
`timescale 1ns / 1ps

module bit_vector_extract_logic_engine_unit_test;
  import bvx_pkg::*;

  localparam int NWORDS = 8;
  localparam int MAXB   = NWORDS * 32;
  localparam int LIMIT  = 1500000;

  typedef struct packed {
    logic [3:0]  act;
    logic        fill;
    logic [2:0]  widx;
    logic [31:0] wdata;
    logic [16:0] offs;
    logic [8:0]  len;
    logic [8:0]  split;
  } bv_item_t;

  typedef struct packed {
    logic [31:0] data;
    logic        last;
    logic        err;
  } bv_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [ACT_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic out_tlast;
  logic out_tuser;

  bit_vector_extract_logic_engine_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast), .out_tuser(out_tuser)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [31:0] vec_a [NWORDS];
  logic [31:0] vec_b [NWORDS];
  int unsigned vec_len = 256;

  bv_item_t pending_items[$];
  bv_word_t expected_words[$];
  int errors = 0;
  int cycles = 0;
  int hold_off = 0;
  int gap_left = 0;
  int burst_left = 0;
  bit bursts_on = 1'b1;

  function automatic logic [31:0] len_mask(int unsigned w);
    int unsigned base;
    base = w * 32;
    if (base >= vec_len) return 32'h0;
    if (vec_len - base >= 32) return 32'hFFFF_FFFF;
    return (32'h1 << (vec_len - base)) - 32'h1;
  endfunction

  function automatic logic a_bit(longint i);
    if (i < 0 || i >= vec_len) return 1'b0;
    return vec_a[i / 32][i % 32];
  endfunction

  function automatic logic b_bit(longint i);
    if (i < 0 || i >= vec_len) return 1'b0;
    return vec_b[i / 32][i % 32];
  endfunction

  task automatic set_length(int unsigned v);
    vec_len = (v == 0) ? 1 : (v > MAXB ? MAXB : v);
    for (int w = 0; w < NWORDS; w++) begin
      vec_a[w] &= len_mask(w);
      vec_b[w] &= len_mask(w);
    end
  endtask

  task automatic push_words(logic [31:0] buf_w [NWORDS], int unsigned bits);
    int unsigned n;
    bv_word_t r;
    n = (bits + 31) / 32;
    for (int k = 0; k < n; k++) begin
      r.data = buf_w[k];
      r.last = (k + 1 == n);
      r.err = 1'b0;
      expected_words.push_back(r);
    end
  endtask

  task automatic push_error();
    bv_word_t r;
    r.data = '0; r.last = 1'b1; r.err = 1'b1;
    expected_words.push_back(r);
  endtask

  // compute the results of one item and update the vectors
  task automatic predict_action(bv_item_t it);
    logic [31:0] buf_w [NWORDS];
    longint off, p;
    int unsigned nw, ln;
    bv_word_t r;
    off = $signed(it.offs);
    nw = (vec_len + 31) / 32;
    for (int w = 0; w < NWORDS; w++) buf_w[w] = '0;
    case (it.act)
      ACT_FILL:
        for (int w = 0; w < NWORDS; w++) vec_a[w] = it.fill ? len_mask(w) : 32'h0;
      ACT_WRA:
        if (it.widx < nw) vec_a[it.widx] = it.wdata & len_mask(it.widx);
      ACT_WRB:
        if (it.widx < nw) vec_b[it.widx] = it.wdata & len_mask(it.widx);
      ACT_NOT, ACT_AND, ACT_OR, ACT_XOR:
        for (int w = 0; w < NWORDS; w++) begin
          case (it.act)
            ACT_NOT: vec_a[w] = ~vec_a[w];
            ACT_AND: vec_a[w] = vec_a[w] & vec_b[w];
            ACT_OR:  vec_a[w] = vec_a[w] | vec_b[w];
            default: vec_a[w] = vec_a[w] ^ vec_b[w];
          endcase
          vec_a[w] &= len_mask(w);
        end
      ACT_GETBIT: begin
        r.data = {31'h0, a_bit(off)}; r.last = 1'b1; r.err = 1'b0;
        expected_words.push_back(r);
      end
      ACT_RDWORD: begin
        r.data = (it.widx < nw) ? vec_a[it.widx] : 32'h0;
        r.last = 1'b1; r.err = 1'b0;
        expected_words.push_back(r);
      end
      ACT_EXTZ, ACT_EXTW: begin
        if (it.len == 0) push_error();
        else begin
          ln = (it.len > MAXB) ? MAXB : it.len;
          for (int j = 0; j < ln; j++) begin
            p = off + j;
            if (it.act == ACT_EXTW) begin
              p = p % longint'(vec_len);
              if (p < 0) p += vec_len;
            end
            buf_w[j / 32][j % 32] = a_bit(p);
          end
          push_words(buf_w, ln);
        end
      end
      ACT_JOIN: begin
        if (it.split > vec_len) push_error();
        else begin
          for (int j = 0; j < vec_len; j++)
            buf_w[j / 32][j % 32] = (j < it.split) ? a_bit(j) : b_bit(j);
          push_words(buf_w, vec_len);
        end
      end
      default: ;
    endcase
  endtask

  function automatic bv_item_t rand_item();
    bv_item_t it;
    it.act = $urandom_range(0, 99) < 2 ? 4'($urandom_range(12, 15))
                                       : 4'($urandom_range(0, 11));
    it.fill = 1'($urandom_range(0, 1));
    it.widx = 3'($urandom_range(0, 7));
    it.wdata = $urandom();
    case ($urandom_range(0, 3))
      0: it.offs = 17'($urandom());
      1: it.offs = 17'($signed($urandom_range(0, 600)) - 300);
      default: it.offs = 17'($urandom_range(0, 300));
    endcase
    // mostly short extracts, some full length, rare zero
    case ($urandom_range(0, 9))
      0: it.len = 9'd0;
      1: it.len = 9'($urandom_range(257, 511));
      2: it.len = 9'd256;
      default: it.len = 9'($urandom_range(1, 96));
    endcase
    it.split = $urandom_range(0, 9) == 0 ? 9'($urandom()) : 9'($urandom_range(0, 256));
    return it;
  endfunction

  function automatic bv_item_t mk(logic [3:0] a, int wi, logic [31:0] wd,
                                  int o, int l, int s, int f);
    bv_item_t it;
    it.act = a; it.widx = 3'(wi); it.wdata = wd; it.offs = 17'(o);
    it.len = 9'(l); it.split = 9'(s); it.fill = 1'(f);
    return it;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_v);
    errors++;
    $display("mismatch %s: got %h expected %h at %0t", what, got, exp_v, $realtime);
  endtask

  function automatic logic [IN_TDATA_W-1:0] in_tdata_pack(bv_item_t it);
    return IN_TDATA_W'({it.split, it.len, it.offs, it.wdata, it.widx, it.fill});
  endfunction

  // driver: bursts of items with random gaps
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) predict_action(pending_items.pop_front());
      if (!(in_tvalid && !in_tready)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (pending_items.size() > (in_tvalid && in_tready ? 0 : 0) &&
                     pending_items.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tdata <= {in_tdata_pack(pending_items[0])};
          in_tuser <= pending_items[0].act;
          if (bursts_on && burst_left == 0) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= $urandom_range(0, 4);
          end else if (burst_left > 0) burst_left <= burst_left - 1;
        end else in_tvalid <= 1'b0;
      end
    end
  end

  // receiver stall pattern plus long hold-off
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else out_tready <= rst_n && ((cycles % 16) < 9 || $urandom_range(0, 2) != 0);
  end

  // monitor
  always @(posedge clk) begin
    bv_word_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", out_tdata, 32'h0);
      end else begin
        e = expected_words.pop_front();
        if (out_tdata !== e.data) report_mismatch("data", out_tdata, e.data);
        if (out_tlast !== e.last) report_mismatch("last", out_tlast, e.last);
        if (out_tuser !== e.err) report_mismatch("error", out_tuser, e.err);
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= LIMIT) begin
      $display("bit_vector_extract_logic_engine_unit_test: FAIL");
      $finish;
    end
  end

  task automatic run_phase();
    while (pending_items.size() > 0 || in_tvalid) @(posedge clk);
    while (expected_words.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_length(int unsigned v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= CFG_W'(v);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    set_length(v);
  endtask

  initial begin
    int unsigned lengths [6] = '{1, 256, 33, 100, 32, 7};
    for (int w = 0; w < NWORDS; w++) begin
      vec_a[w] = '0;
      vec_b[w] = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes and every action at full length
    pending_items.push_back(mk(ACT_FILL, 0, 0, 0, 0, 0, 1));
    pending_items.push_back(mk(ACT_RDWORD, 7, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(ACT_WRB, 0, 32'hFFFF_FFFF, 0, 0, 0, 0));
    pending_items.push_back(mk(ACT_WRB, 7, 32'hA5A5_5A5A, 0, 0, 0, 0));
    pending_items.push_back(mk(ACT_XOR, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(ACT_GETBIT, 0, 0, 17'd255, 0, 0, 0));
    pending_items.push_back(mk(ACT_GETBIT, 0, 0, 17'h1FFFF, 0, 0, 0));
    pending_items.push_back(mk(ACT_GETBIT, 0, 0, 17'd256, 0, 0, 0));
    pending_items.push_back(mk(ACT_WRA, 3, 32'h1234_5678, 0, 0, 0, 0));
    pending_items.push_back(mk(ACT_NOT, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(ACT_OR, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(ACT_AND, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(ACT_EXTZ, 0, 0, 17'h1FFF0, 9'd256, 0, 0));
    pending_items.push_back(mk(ACT_EXTZ, 0, 0, 17'h0FFFF, 9'd511, 0, 0));
    pending_items.push_back(mk(ACT_EXTZ, 0, 0, 17'h10000, 9'd0, 0, 0));
    pending_items.push_back(mk(ACT_EXTW, 0, 0, 17'h10000, 9'd300, 0, 0));
    pending_items.push_back(mk(ACT_EXTW, 0, 0, 17'd250, 9'd1, 0, 0));
    pending_items.push_back(mk(ACT_JOIN, 0, 0, 0, 0, 9'd0, 0));
    pending_items.push_back(mk(ACT_JOIN, 0, 0, 0, 0, 9'd256, 0));
    pending_items.push_back(mk(ACT_JOIN, 0, 0, 0, 0, 9'd100, 0));
    pending_items.push_back(mk(4'd15, 7, 32'hFFFF_FFFF, 17'h1FFFF, 9'h1FF, 9'h1FF, 1));
    pending_items.push_back(mk(ACT_FILL, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(ACT_RDWORD, 0, 0, 0, 0, 0, 0));
    run_phase();

    // long receiver hold-off while items keep coming
    hold_off = 400;
    for (int i = 0; i < 20; i++) pending_items.push_back(rand_item());
    run_phase();

    // random phases across several lengths, zero length register included
    for (int ph = 0; ph < 7; ph++) begin
      write_length(ph == 6 ? 0 : lengths[ph]);
      bursts_on = (ph % 3 != 2);
      for (int i = 0; i < 25; i++) pending_items.push_back(rand_item());
      run_phase();
    end

    if (errors == 0) begin
      $display("bit_vector_extract_logic_engine_unit_test: PASS");
    end else begin
      $display("bit_vector_extract_logic_engine_unit_test: FAIL");
    end
    $finish;
  end

endmodule

### files.f
sv/bvx_pkg.sv
sv/bvx_datapath.sv
sv/bvx_ctrl.sv
sv/bit_vector_extract_logic_engine_unit.sv
tb/sv/bit_vector_extract_logic_engine_unit_test.sv
